@@ rtl/lcp_pkg.sv @@
// shared constants and types of the lane compaction packer
package lcp_pkg;

  localparam int LANES  = 8;
  localparam int LANE_W = 32;
  localparam int CNT_W  = $clog2(LANES + 1);
  localparam int HELD_W = $clog2(LANES);
  localparam int POS_W  = $clog2(2 * LANES);

  typedef logic [LANE_W-1:0] lane_word_t;

  typedef enum logic {
    FUNC_PUSH  = 1'b0,
    FUNC_FLUSH = 1'b1
  } func_e;

  // where one input lane lands in the merged vector
  typedef struct packed {
    logic             keep;
    logic [POS_W-1:0] pos;
  } lane_slot_t;

endpackage

@@ rtl/lcp_intf.sv @@
// input and output channel interfaces of the lane compaction packer
interface lcp_in_if import lcp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       func;
  lane_word_t in_lane_0;
  lane_word_t in_lane_1;
  lane_word_t in_lane_2;
  lane_word_t in_lane_3;
  lane_word_t in_lane_4;
  lane_word_t in_lane_5;
  lane_word_t in_lane_6;
  lane_word_t in_lane_7;

  modport source (
    output valid, func, in_lane_0, in_lane_1, in_lane_2, in_lane_3,
           in_lane_4, in_lane_5, in_lane_6, in_lane_7,
    input  ready
  );
  modport sink (
    input  valid, func, in_lane_0, in_lane_1, in_lane_2, in_lane_3,
           in_lane_4, in_lane_5, in_lane_6, in_lane_7,
    output ready
  );
endinterface

interface lcp_out_if import lcp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] out_count;
  lane_word_t       out_lane_0;
  lane_word_t       out_lane_1;
  lane_word_t       out_lane_2;
  lane_word_t       out_lane_3;
  lane_word_t       out_lane_4;
  lane_word_t       out_lane_5;
  lane_word_t       out_lane_6;
  lane_word_t       out_lane_7;

  modport source (
    output valid, out_count, out_lane_0, out_lane_1, out_lane_2, out_lane_3,
           out_lane_4, out_lane_5, out_lane_6, out_lane_7,
    input  ready
  );
  modport sink (
    input  valid, out_count, out_lane_0, out_lane_1, out_lane_2, out_lane_3,
           out_lane_4, out_lane_5, out_lane_6, out_lane_7,
    output ready
  );
endinterface

@@ rtl/lcp_lane.sv @@
// one input lane: keep flag, running count of kept lanes and target slot
module lcp_lane import lcp_pkg::*; (
  input  lane_word_t        lane_i,
  input  logic [HELD_W-1:0] held_cnt_i,
  input  logic [CNT_W-1:0]  prefix_i,
  output logic [CNT_W-1:0]  prefix_o,
  output lane_slot_t        slot_o
);

  logic keep;

  assign keep        = (lane_i != '0);
  assign prefix_o    = prefix_i + CNT_W'(keep);
  assign slot_o.keep = keep;
  // kept lanes go right behind the held ones
  assign slot_o.pos  = POS_W'(held_cnt_i) + POS_W'(prefix_i);

endmodule

@@ rtl/lcp_merge.sv @@
// merging stage: builds the double-width merged vector and splits it
module lcp_merge import lcp_pkg::*; (
  input  lane_word_t        lanes_i    [LANES],
  input  lane_slot_t        slots_i    [LANES],
  input  lane_word_t        held_i     [LANES],
  input  logic [HELD_W-1:0] held_cnt_i,
  input  logic [CNT_W-1:0]  new_cnt_i,
  output lane_word_t        out_lanes_o[LANES],
  output logic [CNT_W-1:0]  out_cnt_o,
  output lane_word_t        nxt_held_o [LANES],
  output logic [HELD_W-1:0] nxt_cnt_o
);

  lane_word_t       merged[2*LANES];
  logic [POS_W-1:0] total;
  logic             full;

  assign total = POS_W'(held_cnt_i) + POS_W'(new_cnt_i);
  assign full  = (total >= POS_W'(LANES));

  always_comb begin
    for (int j = 0; j < 2 * LANES; j++) begin
      merged[j] = '0;
      for (int i = 0; i < LANES; i++) begin
        if (slots_i[i].keep && (slots_i[i].pos == POS_W'(j))) begin
          merged[j] = merged[j] | lanes_i[i];
        end
      end
    end
    for (int j = 0; j < LANES; j++) begin
      if (POS_W'(j) < POS_W'(held_cnt_i)) begin
        merged[j] = held_i[j];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      if (full) begin
        out_lanes_o[j] = merged[j];
        nxt_held_o[j]  = merged[LANES + j];
      end else begin
        out_lanes_o[j] = '0;
        nxt_held_o[j]  = merged[j];
      end
    end
    if (full) begin
      out_cnt_o = CNT_W'(LANES);
      nxt_cnt_o = HELD_W'(total - POS_W'(LANES));
    end else begin
      out_cnt_o = '0;
      nxt_cnt_o = HELD_W'(total);
    end
  end

endmodule

@@ rtl/lane_compaction_packer.sv @@
// lane compaction packer: a push word carries eight 32-bit lanes, zero lanes
// are dropped and the rest are packed in lane order behind up to seven held
// lanes; once eight lanes are gathered a full vector with count 8 goes out
// and the overflow stays held, otherwise the result has count 0. a flush
// word returns the held lanes with their count and empties the store. every
// input word gives exactly one result word, in the cycle after acceptance;
// a word is taken every cycle unless the output stalls, as all eight lanes
// are placed in parallel in the same cycle behind a single output register.
module lane_compaction_packer import lcp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lcp_in_if.sink    in_i,
  lcp_out_if.source out_o
);

  lane_word_t        lanes   [LANES];
  lane_slot_t        slots   [LANES];
  logic [CNT_W-1:0]  prefix  [LANES+1];

  lane_word_t        held_q  [LANES];
  lane_word_t        held_d  [LANES];
  logic [HELD_W-1:0] held_cnt_q, held_cnt_d;

  lane_word_t        mrg_out [LANES];
  lane_word_t        mrg_held[LANES];
  logic [CNT_W-1:0]  mrg_cnt;
  logic [HELD_W-1:0] mrg_nxt_cnt;

  lane_word_t        res_lanes[LANES];
  logic [CNT_W-1:0]  res_cnt;

  lane_word_t        out_lanes_q[LANES];
  logic [CNT_W-1:0]  out_cnt_q;
  logic              out_valid_q;

  logic              accept;

  assign lanes[0] = in_i.in_lane_0;
  assign lanes[1] = in_i.in_lane_1;
  assign lanes[2] = in_i.in_lane_2;
  assign lanes[3] = in_i.in_lane_3;
  assign lanes[4] = in_i.in_lane_4;
  assign lanes[5] = in_i.in_lane_5;
  assign lanes[6] = in_i.in_lane_6;
  assign lanes[7] = in_i.in_lane_7;

  assign prefix[0] = '0;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    lcp_lane u_lane (
      .lane_i    (lanes[g]),
      .held_cnt_i(held_cnt_q),
      .prefix_i  (prefix[g]),
      .prefix_o  (prefix[g+1]),
      .slot_o    (slots[g])
    );
  end

  lcp_merge u_merge (
    .lanes_i    (lanes),
    .slots_i    (slots),
    .held_i     (held_q),
    .held_cnt_i (held_cnt_q),
    .new_cnt_i  (prefix[LANES]),
    .out_lanes_o(mrg_out),
    .out_cnt_o  (mrg_cnt),
    .nxt_held_o (mrg_held),
    .nxt_cnt_o  (mrg_nxt_cnt)
  );

  // flush hands out the held lanes, slots above the count are already zero
  always_comb begin
    if (in_i.func == FUNC_FLUSH) begin
      for (int j = 0; j < LANES; j++) begin
        res_lanes[j] = held_q[j];
        held_d[j]    = '0;
      end
      res_cnt    = CNT_W'(held_cnt_q);
      held_cnt_d = '0;
    end else begin
      for (int j = 0; j < LANES; j++) begin
        res_lanes[j] = mrg_out[j];
        held_d[j]    = mrg_held[j];
      end
      res_cnt    = mrg_cnt;
      held_cnt_d = mrg_nxt_cnt;
    end
  end

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= '0;
      for (int j = 0; j < LANES; j++) begin
        held_q[j] <= '0;
      end
    end else if (accept) begin
      held_cnt_q <= held_cnt_d;
      for (int j = 0; j < LANES; j++) begin
        held_q[j] <= held_d[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_cnt_q <= res_cnt;
      for (int j = 0; j < LANES; j++) begin
        out_lanes_q[j] <= res_lanes[j];
      end
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.out_count  = out_cnt_q;
  assign out_o.out_lane_0 = out_lanes_q[0];
  assign out_o.out_lane_1 = out_lanes_q[1];
  assign out_o.out_lane_2 = out_lanes_q[2];
  assign out_o.out_lane_3 = out_lanes_q[3];
  assign out_o.out_lane_4 = out_lanes_q[4];
  assign out_o.out_lane_5 = out_lanes_q[5];
  assign out_o.out_lane_6 = out_lanes_q[6];
  assign out_o.out_lane_7 = out_lanes_q[7];

endmodule
